// ===== sv/iirt_pkg.sv =====
package iirt_pkg;

   localparam int SAMPLE_W = 16;
   localparam int COEF_W   = 18;
   localparam int TAP_W    = 32;
   localparam int ACC_W    = 56;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic signed [COEF_W-1:0]   coef_type;
   typedef logic signed [TAP_W-1:0]    tap_type;
   typedef logic signed [ACC_W-1:0]    acc_type;
   typedef logic [1:0]                 mode_type;
   typedef logic [2:0]                 csr_index_type;

   localparam mode_type MODE_FILTER = 2'd0;
   localparam mode_type MODE_LOAD   = 2'd1;
   localparam mode_type MODE_READ   = 2'd2;

   localparam csr_index_type CSR_FF_COEF_0 = 3'd0;
   localparam csr_index_type CSR_FF_COEF_1 = 3'd1;
   localparam csr_index_type CSR_FF_COEF_2 = 3'd2;
   localparam csr_index_type CSR_FF_COEF_3 = 3'd3;
   localparam csr_index_type CSR_FB_COEF_1 = 3'd4;
   localparam csr_index_type CSR_FB_COEF_2 = 3'd5;
   localparam csr_index_type CSR_FB_COEF_3 = 3'd6;

   localparam coef_type FF_COEF_0_RESET = 18'sd32768;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_Y,
      ST_FB,
      ST_UPD,
      ST_DONE
   } state_type;

   // phase strobes shared by the head and the cells
   typedef struct packed {
      logic mul_bx;
      logic calc_y;
      logic mul_ay;
      logic update;
      logic load;
   } ctl_type;

   // Q.44 accumulator to Q2.29: round half up, then saturate
   function automatic tap_type to_q29(input acc_type acc);
      acc_type                 rnd;
      logic signed [ACC_W-16:0] q;
      rnd = acc + 56'sd16384;
      q   = (ACC_W-15)'(rnd >>> 15);
      if (q > 41'sd2147483647) begin
         return 32'sh7fff_ffff;
      end else if (q < -41'sd2147483648) begin
         return 32'sh8000_0000;
      end
      return q[TAP_W-1:0];
   endfunction

endpackage

// ===== sv/iirt_if.sv =====
interface iirt_req_if
   import iirt_pkg::*;
();
   logic       valid;
   logic       ready;
   mode_type   mode;
   sample_type sample_in;
   logic [1:0] tap_index;
   tap_type    tap_value;

   modport source (output valid, mode, sample_in, tap_index, tap_value, input ready);
   modport sink   (input valid, mode, sample_in, tap_index, tap_value, output ready);
endinterface

interface iirt_rsp_if
   import iirt_pkg::*;
();
   logic       valid;
   logic       ready;
   sample_type sample_out;
   logic       clipped;
   tap_type    tap_read;

   modport source (output valid, sample_out, clipped, tap_read, input ready);
   modport sink   (input valid, sample_out, clipped, tap_read, output ready);
endinterface

interface iirt_csr_if
   import iirt_pkg::*;
();
   logic          valid;
   logic          ready;
   csr_index_type index;
   coef_type      data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/iirt_head.sv =====
module iirt_head
   import iirt_pkg::*;
(
   input  logic       clock,
   input  ctl_type    ctl,
   input  coef_type   b_coef,
   input  sample_type sample_in,
   input  tap_type    z_first,
   output tap_type    y,
   output sample_type sample_out,
   output logic       clipped
);

   logic signed [COEF_W+SAMPLE_W-1:0] b0x_ff, b0x_in;
   tap_type                           y_ff, y_in;
   acc_type                           y_acc;
   logic signed [TAP_W+1:0]           y_rnd;
   logic signed [TAP_W-12:0]          y_sh;

   always_comb begin
      b0x_in = ctl.mul_bx ? b_coef * sample_in : b0x_ff;
      y_acc  = (ACC_W'(z_first) <<< 15) + (ACC_W'(b0x_ff) <<< 14);
      y_in   = ctl.calc_y ? to_q29(y_acc) : y_ff;
   end

   always_ff @(posedge clock) begin
      b0x_ff <= b0x_in;
      y_ff   <= y_in;
   end

   // Q2.29 to Q1.15, round half up and saturate
   always_comb begin
      y_rnd   = (TAP_W+2)'(y_ff) + 34'sd8192;
      y_sh    = (TAP_W-11)'(y_rnd >>> 14);
      clipped = 1'b0;
      if (y_sh > 21'sd32767) begin
         sample_out = 16'sh7fff;
         clipped    = 1'b1;
      end else if (y_sh < -21'sd32768) begin
         sample_out = 16'sh8000;
         clipped    = 1'b1;
      end else begin
         sample_out = y_sh[SAMPLE_W-1:0];
      end
   end

   assign y = y_ff;

endmodule

// ===== sv/iirt_cell.sv =====
module iirt_cell
   import iirt_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  ctl_type    ctl,
   input  coef_type   b_coef,
   input  coef_type   a_coef,
   input  sample_type sample_in,
   input  tap_type    y,
   input  tap_type    z_next,
   input  tap_type    load_value,
   output tap_type    z
);

   logic signed [COEF_W+SAMPLE_W-1:0] bx_ff, bx_in;
   logic signed [COEF_W+TAP_W-1:0]    ay_ff, ay_in;
   tap_type                           z_ff, z_in;
   acc_type                           acc;

   always_comb begin
      bx_in = ctl.mul_bx ? b_coef * sample_in : bx_ff;
      ay_in = ctl.mul_ay ? a_coef * y : ay_ff;
      acc   = (ACC_W'(z_next) <<< 15) + (ACC_W'(bx_ff) <<< 14) - ACC_W'(ay_ff);
      z_in  = z_ff;
      if (ctl.update) begin
         z_in = to_q29(acc);
      end else if (ctl.load) begin
         z_in = load_value;
      end
   end

   always_ff @(posedge clock) begin
      bx_ff <= bx_in;
      ay_ff <= ay_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         z_ff <= '0;
      end else begin
         z_ff <= z_in;
      end
   end

   assign z = z_ff;

endmodule

// ===== sv/iir_filter_transposed_df2_top.sv =====
// Third-order IIR filter, transposed direct form II (a0 = 1).
// Channels: req (mode, sample_in, tap_index, tap_value) in, rsp (sample_out,
// clipped, tap_read) out, csr writes coefficient registers 0..6 (b0..b3,
// a1..a3, Q2.15). All use valid/ready; a transfer happens when both are high.
// csr is always ready; write it only while no request is in flight.
// One request is worked at a time. A filter request steps from accept
// through product, output, feedback product and tap update in the cell row,
// then the result register is loaded and rsp valid rises with it. Load and
// read requests go from accept straight to loading the result register. The
// two multiplier stages (b*x, then a*y) are separate steps of the sequence.
// Each cell of the row holds one delay element and takes its neighbor's old
// value on update, so all taps move in the same cycle.
// Reset clears the delay line, sets b0 = 1.0 and all other coefficients to
// zero, and empties the result register.
// When rsp stalls, the result holds; a new request is still accepted and is
// worked up to its result, which then waits for the register to free.
module iir_filter_transposed_df2_top
   import iirt_pkg::*;
#(
   parameter int ORDER = 3
) (
   input logic        clock,
   input logic        reset,
   iirt_req_if.sink   req,
   iirt_rsp_if.source rsp,
   iirt_csr_if.sink   csr
);

   state_type state_ff, state_in;
   ctl_type   ctl;
   ctl_type   cell_ctl [ORDER];
   logic      out_load;

   coef_type ff_coef_ff [4];
   coef_type fb_coef_ff [3];

   mode_type   mode_ff;
   sample_type sample_ff;
   logic [1:0] index_ff;
   tap_type    value_ff;

   tap_type    z_bus [ORDER+1];
   tap_type    y;
   sample_type head_sample;
   logic       head_clipped;
   tap_type    tap_sel;

   logic       rsp_valid_ff, rsp_valid_in;
   sample_type sample_out_ff, sample_out_in;
   logic       clipped_ff, clipped_in;
   tap_type    tap_read_ff, tap_read_in;

   // coefficient registers
   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         ff_coef_ff[0] <= FF_COEF_0_RESET;
         ff_coef_ff[1] <= '0;
         ff_coef_ff[2] <= '0;
         ff_coef_ff[3] <= '0;
         fb_coef_ff[0] <= '0;
         fb_coef_ff[1] <= '0;
         fb_coef_ff[2] <= '0;
      end else if (csr.valid) begin
         unique case (csr.index)
            CSR_FF_COEF_0: ff_coef_ff[0] <= csr.data;
            CSR_FF_COEF_1: ff_coef_ff[1] <= csr.data;
            CSR_FF_COEF_2: ff_coef_ff[2] <= csr.data;
            CSR_FF_COEF_3: ff_coef_ff[3] <= csr.data;
            CSR_FB_COEF_1: fb_coef_ff[0] <= csr.data;
            CSR_FB_COEF_2: fb_coef_ff[1] <= csr.data;
            CSR_FB_COEF_3: fb_coef_ff[2] <= csr.data;
            default: ;
         endcase
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               state_in = (req.mode == MODE_FILTER) ? ST_MUL : ST_DONE;
            end
         end
         ST_MUL:  state_in = ST_Y;
         ST_Y:    state_in = ST_FB;
         ST_FB:   state_in = ST_UPD;
         ST_UPD:  state_in = ST_DONE;
         ST_DONE: begin
            if (!rsp_valid_ff || rsp.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req.ready  = 1'b0;
      out_load   = 1'b0;
      ctl        = '0;
      unique case (state_ff)
         ST_IDLE: req.ready  = 1'b1;
         ST_MUL:  ctl.mul_bx = 1'b1;
         ST_Y:    ctl.calc_y = 1'b1;
         ST_FB:   ctl.mul_ay = 1'b1;
         ST_UPD:  ctl.update = 1'b1;
         ST_DONE: begin
            out_load = !rsp_valid_ff || rsp.ready;
            ctl.load = out_load && (mode_ff == MODE_LOAD);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // request capture
   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         mode_ff   <= req.mode;
         sample_ff <= req.sample_in;
         index_ff  <= req.tap_index;
         value_ff  <= req.tap_value;
      end
   end

   // cell row
   iirt_head u_head (
      .clock      (clock),
      .ctl        (ctl),
      .b_coef     (ff_coef_ff[0]),
      .sample_in  (sample_ff),
      .z_first    (z_bus[0]),
      .y          (y),
      .sample_out (head_sample),
      .clipped    (head_clipped)
   );

   assign z_bus[ORDER] = '0;

   for (genvar j = 0; j < ORDER; j++) begin : g_cell
      always_comb begin
         cell_ctl[j]      = ctl;
         cell_ctl[j].load = ctl.load && (index_ff == 2'(j));
      end

      iirt_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (cell_ctl[j]),
         .b_coef     (ff_coef_ff[j+1]),
         .a_coef     (fb_coef_ff[j]),
         .sample_in  (sample_ff),
         .y          (y),
         .z_next     (z_bus[j+1]),
         .load_value (value_ff),
         .z          (z_bus[j])
      );
   end

   // tap read: out-of-range index reads zero
   always_comb begin
      tap_sel = '0;
      for (int j = 0; j < ORDER; j++) begin
         if (index_ff == 2'(j)) begin
            tap_sel = z_bus[j];
         end
      end
   end

   // result register
   always_comb begin
      sample_out_in = sample_out_ff;
      clipped_in    = clipped_ff;
      tap_read_in   = tap_read_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      if (out_load) begin
         rsp_valid_in  = 1'b1;
         sample_out_in = '0;
         clipped_in    = 1'b0;
         tap_read_in   = '0;
         if (mode_ff == MODE_FILTER) begin
            sample_out_in = head_sample;
            clipped_in    = head_clipped;
         end else if (mode_ff == MODE_READ) begin
            tap_read_in = tap_sel;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_out_ff <= sample_out_in;
      clipped_ff    <= clipped_in;
      tap_read_ff   <= tap_read_in;
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.sample_out = sample_out_ff;
   assign rsp.clipped    = clipped_ff;
   assign rsp.tap_read   = tap_read_ff;

endmodule

// ===== sv/iirt_checker.sv =====
module iirt_checker
   import iirt_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input sample_type sample_out,
   input logic       clipped,
   input tap_type    tap_read
);

   // a waiting response stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // a reset leaves the result register empty
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // saturation flag only with a full-scale sample and no tap data
   a_clip_rail: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && clipped |->
         (sample_out == 16'sh7fff || sample_out == 16'sh8000) && tap_read == '0)
      else $error("clipped set without a saturated sample");

   // tap data comes only from a read request, which carries no sample
   a_tap_only: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && tap_read != '0 |-> sample_out == '0 && !clipped)
      else $error("tap read mixed with sample output");

endmodule

bind iir_filter_transposed_df2_top iirt_checker u_iirt_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp.valid),
   .rsp_ready  (rsp.ready),
   .sample_out (rsp.sample_out),
   .clipped    (rsp.clipped),
   .tap_read   (rsp.tap_read)
);
